FILE: rtl/pbcr_pkg.sv
// shared types and constants of the priority bank cache replacer
// no dependencies; used by priority_bank_cache_replacer_core
`default_nettype none

package pbcr_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MISS_UPD,
    S_CACHE,
    S_BANK_CHK,
    S_HIT,
    S_PROBE,
    S_COMMIT,
    S_DONE
  } state_t;

  localparam logic       OP_CACHE = 1'b0;
  localparam logic       OP_MISS  = 1'b1;

  localparam logic [2:0] STAT_HIT     = 3'd0;
  localparam logic [2:0] STAT_MAPPED  = 3'd1;
  localparam logic [2:0] STAT_NOFREE  = 3'd2;
  localparam logic [2:0] STAT_MISS    = 3'd3;
  localparam logic [2:0] STAT_IGNORED = 3'd4;

  localparam logic [1:0] CFG_HIROM       = 2'd0;
  localparam logic [1:0] CFG_BANK_COUNT  = 2'd1;
  localparam logic [1:0] CFG_CHUNK_COUNT = 2'd2;

  localparam logic [7:0] BANK_IGN_LO   = 8'h7E;
  localparam logic [7:0] BANK_IGN_HI   = 8'h7F;
  localparam logic [7:0] TYPE_RESIDENT = 8'hFF;
  localparam logic [7:0] TYPE_MISS     = 8'h40;
  localparam logic [7:0] TYPE_NONE     = 8'h00;
  localparam logic [7:0] HIROM_BASE    = 8'h40;
  localparam logic [2:0] MISS_LIMIT    = 3'd4;

  localparam logic [7:0] RST_BANK_COUNT  = 8'd1;
  localparam logic [6:0] RST_CHUNK_COUNT = 7'd64;

endpackage

`default_nettype wire

FILE: rtl/priority_bank_cache_replacer_core.sv
// Maps ROM banks to buffer chunks: cache requests and miss reports produce one result item
// each. After reset a clearing pass zeroes the chunk, bank and miss tables with no item
// taken. A miss report below the threshold runs the miss update and done steps, an ignored
// bank only the done step, a cached bank the cache, bank check, hit and done steps; a new
// mapping runs cache, bank check, one probe step per chunk probed, commit and done. The
// probe loop reads the chunk table once per cycle through its single read port.
// One item is worked on at a time; a result waits in the done step for the output register.
// depends on pbcr_pkg
`default_nettype none

module priority_bank_cache_replacer_core #(
  parameter int MAX_CHUNKS = 64,
  parameter int BANK_SLOTS = 128,
  parameter int MISS_SLOTS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  bank,
  input  wire logic [7:0]  usage_type,
  input  wire logic [23:0] rom_offset,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  status,
  output      logic        evicted_valid,
  output      logic [6:0]  evicted_bank,
  output      logic [6:0]  mapped_bank,
  output      logic [5:0]  chunk_index
);

  localparam int CW = $clog2(MAX_CHUNKS);
  localparam int NW = $clog2(MAX_CHUNKS + 1);
  localparam int BW = $clog2(BANK_SLOTS);
  localparam int KW = $clog2(MISS_SLOTS);
  localparam int CLR_A = (MAX_CHUNKS > BANK_SLOTS) ? MAX_CHUNKS : BANK_SLOTS;
  localparam int CLR_LEN = (CLR_A > MISS_SLOTS) ? CLR_A : MISS_SLOTS;
  localparam int LW = $clog2(CLR_LEN);
  localparam int CE = 8 + BW;
  localparam int BE = 1 + CW;

  // configuration
  logic       hirom_mode;
  logic [7:0] bank_count;
  logic [6:0] chunk_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hirom_mode  <= 1'b0;
      bank_count  <= pbcr_pkg::RST_BANK_COUNT;
      chunk_count <= pbcr_pkg::RST_CHUNK_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        pbcr_pkg::CFG_HIROM:       hirom_mode  <= cfg_data[0];
        pbcr_pkg::CFG_BANK_COUNT:  bank_count  <= cfg_data;
        pbcr_pkg::CFG_CHUNK_COUNT: chunk_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [CE-1:0] cmem [MAX_CHUNKS];
  logic [BE-1:0] bmem [BANK_SLOTS];
  logic [2:0]    mmem [MISS_SLOTS];

  logic          cm_we, bm_we, mm_we;
  logic [CW-1:0] cm_waddr, cm_raddr;
  logic [BW-1:0] bm_waddr, bm_raddr;
  logic [KW-1:0] mm_waddr, mm_raddr;
  logic [CE-1:0] cm_wdata, cm_rdata;
  logic [BE-1:0] bm_wdata, bm_rdata;
  logic [2:0]    mm_wdata, mm_rdata;

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    cm_rdata <= cmem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bmem[bm_waddr] <= bm_wdata;
    end
    bm_rdata <= bmem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (mm_we) begin
      mmem[mm_waddr] <= mm_wdata;
    end
    mm_rdata <= mmem[mm_raddr];
  end

  localparam logic [7:0] HIROM_LIM = pbcr_pkg::HIROM_BASE;

  // bank after mask, hirom offset and wrap into the bank table
  function automatic logic [BW-1:0] calc_bank(input logic [8:0] raw_in, input logic hi,
                                              input logic [7:0] cnt);
    logic [7:0] m;
    logic [8:0] v;
    m = cnt - 8'd1;
    v = {1'b0, raw_in[7:0] & m};
    if (hi && (v < 9'(HIROM_LIM))) begin
      v = v + 9'(HIROM_LIM);
    end
    for (int j = 0; j < 4; j++) begin
      if (v >= 9'(BANK_SLOTS)) begin
        v = v - 9'(BANK_SLOTS);
      end
    end
    return BW'(v);
  endfunction

  function automatic logic [KW-1:0] calc_slot(input logic [8:0] mb_in);
    logic [10:0] v;
    v = 11'(mb_in);
    for (int j = 0; j < 4; j++) begin
      if (v >= 11'(MISS_SLOTS)) begin
        v = v - 11'(MISS_SLOTS);
      end
    end
    return KW'(v);
  endfunction

  // control and working registers
  pbcr_pkg::state_t state, state_next;
  logic [LW-1:0] clr, clr_next;
  logic [8:0]    raw, raw_next;
  logic [7:0]    tp, tp_next;
  logic [BW-1:0] breg, breg_next;
  logic [CW-1:0] creg, creg_next;
  logic [CW-1:0] p, p_next;
  logic [NW-1:0] pcnt, pcnt_next;
  logic [KW-1:0] kreg, kreg_next;
  logic [CW-1:0] next_chunk, next_chunk_next;
  logic [2:0]    res_status, res_status_next;
  logic          res_ev, res_ev_next;
  logic [6:0]    res_evb, res_evb_next;
  logic [6:0]    res_mb, res_mb_next;
  logic [5:0]    res_ci, res_ci_next;
  logic          out_load;

  // derived values
  logic [8:0]    mb_in;
  logic [KW-1:0] k_calc;
  logic [BW-1:0] b_calc;
  logic [8:0]    cc9;
  logic [NW-1:0] n_cur, first_cur, p_inc;
  logic [CW-1:0] p0, p_wrap;
  logic [7:0]    ct;
  logic [BW-1:0] old_bank;
  logic          ok;
  logic [2:0]    miss_cnt;

  assign mb_in  = hirom_mode ? 9'(rom_offset[23:16]) : rom_offset[23:15];
  assign k_calc = calc_slot(mb_in);
  assign b_calc = calc_bank(raw, hirom_mode, bank_count);
  assign cc9    = 9'(chunk_count);

  always_comb begin
    if (chunk_count == 7'd0) begin
      n_cur = NW'(1);
    end else if (cc9 > 9'(MAX_CHUNKS)) begin
      n_cur = NW'(MAX_CHUNKS);
    end else begin
      n_cur = NW'(chunk_count);
    end
  end

  assign first_cur = (tp == pbcr_pkg::TYPE_RESIDENT) ? '0 : (n_cur >> 1);
  assign p0        = (NW'(next_chunk) >= n_cur) ? CW'(first_cur) : next_chunk;
  assign p_inc     = NW'(p) + NW'(1);
  assign p_wrap    = (p_inc >= n_cur) ? CW'(first_cur) : CW'(p_inc);
  assign ct        = cm_rdata[CE-1:BW];
  assign old_bank  = cm_rdata[BW-1:0];
  assign miss_cnt  = mm_rdata + 3'd1;

  always_comb begin
    if (ct == pbcr_pkg::TYPE_RESIDENT) begin
      ok = 1'b0;
    end else if (tp[7]) begin
      ok = !ct[7] || (ct == tp);
    end else begin
      ok = (ct <= tp);
    end
  end

  assign in_stall = (state != pbcr_pkg::S_IDLE);

  always_comb begin
    state_next      = state;
    clr_next        = clr;
    raw_next        = raw;
    tp_next         = tp;
    breg_next       = breg;
    creg_next       = creg;
    p_next          = p;
    pcnt_next       = pcnt;
    kreg_next       = kreg;
    next_chunk_next = next_chunk;
    res_status_next = res_status;
    res_ev_next     = res_ev;
    res_evb_next    = res_evb;
    res_mb_next     = res_mb;
    res_ci_next     = res_ci;
    out_load        = 1'b0;
    cm_we           = 1'b0;
    cm_waddr        = p;
    cm_wdata        = {tp, breg};
    cm_raddr        = p;
    bm_we           = 1'b0;
    bm_waddr        = breg;
    bm_wdata        = {1'b1, p};
    bm_raddr        = breg;
    mm_we           = 1'b0;
    mm_waddr        = kreg;
    mm_wdata        = miss_cnt;
    mm_raddr        = kreg;

    case (state)
      pbcr_pkg::S_CLEAR: begin
        cm_we    = ((LW + 1)'(clr) < (LW + 1)'(MAX_CHUNKS));
        cm_waddr = CW'(clr);
        cm_wdata = '0;
        bm_we    = ((LW + 1)'(clr) < (LW + 1)'(BANK_SLOTS));
        bm_waddr = BW'(clr);
        bm_wdata = '0;
        mm_we    = ((LW + 1)'(clr) < (LW + 1)'(MISS_SLOTS));
        mm_waddr = KW'(clr);
        mm_wdata = '0;
        clr_next = clr + LW'(1);
        if (clr == LW'(CLR_LEN - 1)) begin
          state_next = pbcr_pkg::S_IDLE;
        end
      end

      pbcr_pkg::S_IDLE: begin
        mm_raddr = k_calc;
        if (in_valid) begin
          res_ev_next  = 1'b0;
          res_evb_next = '0;
          res_mb_next  = '0;
          res_ci_next  = '0;
          if (op == pbcr_pkg::OP_CACHE) begin
            raw_next = 9'(bank);
            tp_next  = usage_type;
            if ((bank == pbcr_pkg::BANK_IGN_LO) || (bank == pbcr_pkg::BANK_IGN_HI)) begin
              res_status_next = pbcr_pkg::STAT_IGNORED;
              state_next      = pbcr_pkg::S_DONE;
            end else begin
              state_next = pbcr_pkg::S_CACHE;
            end
          end else begin
            raw_next   = mb_in;
            kreg_next  = k_calc;
            state_next = pbcr_pkg::S_MISS_UPD;
          end
        end
      end

      pbcr_pkg::S_MISS_UPD: begin
        mm_we = 1'b1;
        if (miss_cnt > pbcr_pkg::MISS_LIMIT) begin
          mm_wdata   = '0;
          tp_next    = pbcr_pkg::TYPE_MISS;
          state_next = pbcr_pkg::S_CACHE;
        end else begin
          mm_wdata        = miss_cnt;
          res_status_next = pbcr_pkg::STAT_MISS;
          state_next      = pbcr_pkg::S_DONE;
        end
      end

      pbcr_pkg::S_CACHE: begin
        bm_raddr   = b_calc;
        breg_next  = b_calc;
        state_next = pbcr_pkg::S_BANK_CHK;
      end

      pbcr_pkg::S_BANK_CHK: begin
        if (bm_rdata[CW]) begin
          creg_next  = bm_rdata[CW-1:0];
          cm_raddr   = bm_rdata[CW-1:0];
          state_next = pbcr_pkg::S_HIT;
        end else begin
          p_next     = p0;
          cm_raddr   = p0;
          pcnt_next  = '0;
          state_next = pbcr_pkg::S_PROBE;
        end
      end

      pbcr_pkg::S_HIT: begin
        cm_waddr = creg;
        cm_wdata = {tp, old_bank};
        cm_we    = (ct < tp);
        res_status_next = pbcr_pkg::STAT_HIT;
        res_mb_next     = 7'(breg);
        res_ci_next     = 6'(creg);
        state_next      = pbcr_pkg::S_DONE;
      end

      pbcr_pkg::S_PROBE: begin
        if (ok) begin
          cm_we    = 1'b1;
          cm_waddr = p;
          cm_wdata = {tp, breg};
          bm_waddr = old_bank;
          bm_wdata = '0;
          if (ct != pbcr_pkg::TYPE_NONE) begin
            bm_we        = 1'b1;
            res_ev_next  = 1'b1;
            res_evb_next = 7'(old_bank);
          end
          res_status_next = pbcr_pkg::STAT_MAPPED;
          res_mb_next     = 7'(breg);
          res_ci_next     = 6'(p);
          state_next      = pbcr_pkg::S_COMMIT;
        end else if (pcnt == (n_cur - NW'(1))) begin
          res_status_next = pbcr_pkg::STAT_NOFREE;
          res_mb_next     = 7'(breg);
          state_next      = pbcr_pkg::S_DONE;
        end else begin
          p_next    = p_wrap;
          cm_raddr  = p_wrap;
          pcnt_next = pcnt + NW'(1);
        end
      end

      pbcr_pkg::S_COMMIT: begin
        bm_we           = 1'b1;
        bm_waddr        = breg;
        bm_wdata        = {1'b1, p};
        next_chunk_next = p_wrap;
        state_next      = pbcr_pkg::S_DONE;
      end

      pbcr_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = pbcr_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pbcr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pbcr_pkg::S_CLEAR;
      clr        <= '0;
      next_chunk <= '0;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      next_chunk <= next_chunk_next;
    end
  end

  always_ff @(posedge clk) begin
    raw        <= raw_next;
    tp         <= tp_next;
    breg       <= breg_next;
    creg       <= creg_next;
    p          <= p_next;
    pcnt       <= pcnt_next;
    kreg       <= kreg_next;
    res_status <= res_status_next;
    res_ev     <= res_ev_next;
    res_evb    <= res_evb_next;
    res_mb     <= res_mb_next;
    res_ci     <= res_ci_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      evicted_valid <= res_ev;
      evicted_bank  <= res_evb;
      mapped_bank   <= res_mb;
      chunk_index   <= res_ci;
    end
  end

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pbcr_pkg::S_PROBE) |-> (pcnt < n_cur))
    else $error("probe count ran past the chunk count");

  a_evict_only_mapped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted_valid) |-> (status == pbcr_pkg::STAT_MAPPED))
    else $error("eviction reported without a new mapping");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == pbcr_pkg::S_DONE))
    else $error("result item raised outside the done step");

  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    (state == pbcr_pkg::S_IDLE) |-> (NW'(next_chunk) < NW'(MAX_CHUNKS)))
    else $error("round-robin pointer out of range");

endmodule

`default_nettype wire

FILE: dv/tb_priority_bank_cache_replacer_core.sv
// testbench of priority_bank_cache_replacer_core: directed and random cache requests and
// miss reports, each outcome checked against an in-bench model of the chunk tables
// depends on pbcr_pkg and priority_bank_cache_replacer_core
`timescale 1ns / 100ps

module tb_priority_bank_cache_replacer_core;
  import pbcr_pkg::*;

  localparam int NUM_CHUNKS = 64;
  localparam int NUM_BANKS  = 128;
  localparam int NUM_MISS   = 512;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic        op;
    logic [7:0]  bank;
    logic [7:0]  usage_type;
    logic [23:0] rom_offset;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       evicted_valid;
    logic [6:0] evicted_bank;
    logic [6:0] mapped_bank;
    logic [5:0] chunk_index;
  } map_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_HIROM;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_CACHE;
  logic [7:0]  bank = 8'd0;
  logic [7:0]  usage_type = 8'd0;
  logic [23:0] rom_offset = 24'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        evicted_valid;
  logic [6:0]  evicted_bank;
  logic [6:0]  mapped_bank;
  logic [5:0]  chunk_index;

  // model of the block's tables and registers
  bit          bank_held [NUM_BANKS];
  logic [5:0]  bank_chunk [NUM_BANKS];
  logic [7:0]  chunk_type [NUM_CHUNKS];
  logic [7:0]  chunk_bank [NUM_CHUNKS];
  int          next_ptr;
  logic [2:0]  miss_cnt [NUM_MISS];
  logic        hirom_q;
  logic [7:0]  bank_count_q;
  logic [6:0]  chunk_count_q;

  req_t        req_backlog[$];
  map_res_t    chunk_decisions[$];
  req_t        cur_req;
  map_res_t    want_res;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 48;

  priority_bank_cache_replacer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .bank          (bank),
    .usage_type    (usage_type),
    .rom_offset    (rom_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .evicted_valid (evicted_valid),
    .evicted_bank  (evicted_bank),
    .mapped_bank   (mapped_bank),
    .chunk_index   (chunk_index)
  );

  always #1 clk = ~clk;

  function automatic map_res_t map_bank(input logic [7:0] raw, input logic [7:0] typ);
    map_res_t   r;
    logic [7:0] msk;
    int         b;
    int         n;
    int         wrap_to;
    int         p;
    int         c;
    int         i;
    bit         found;
    bit         ok;
    logic [7:0] ct;
    r = '0;
    msk = bank_count_q - 8'd1;
    b = raw & msk;
    if (hirom_q && b < 'h40) b = b + HIROM_BASE;
    b = b % NUM_BANKS;
    n = chunk_count_q;
    if (n == 0) n = 1;
    if (n > NUM_CHUNKS) n = NUM_CHUNKS;
    wrap_to = (typ == TYPE_RESIDENT) ? 0 : n / 2;
    r.mapped_bank = b[6:0];
    if (bank_held[b]) begin
      c = bank_chunk[b];
      if (chunk_type[c] < typ) chunk_type[c] = typ;
      r.status = STAT_HIT;
      r.chunk_index = c[5:0];
      return r;
    end
    p = next_ptr;
    if (p >= n) p = wrap_to;
    found = 1'b0;
    for (i = 0; i < n && !found; i++) begin
      ct = chunk_type[p];
      if (ct == TYPE_RESIDENT) ok = 1'b0;
      else if (typ[7]) ok = !ct[7] || ct == typ;
      else ok = ct <= typ;
      if (ok) begin
        found = 1'b1;
      end else begin
        p++;
        if (p >= n) p = wrap_to;
      end
    end
    if (!found) begin
      r.status = STAT_NOFREE;
      return r;
    end
    // a chunk of type zero counts as empty, so its old bank stays marked as held
    if (chunk_type[p] != TYPE_NONE) begin
      bank_held[chunk_bank[p] % NUM_BANKS] = 1'b0;
      r.evicted_valid = 1'b1;
      r.evicted_bank = chunk_bank[p][6:0];
    end
    chunk_type[p] = typ;
    chunk_bank[p] = b[7:0];
    bank_held[b] = 1'b1;
    bank_chunk[b] = p[5:0];
    r.status = STAT_MAPPED;
    r.chunk_index = p[5:0];
    p++;
    if (p >= n) p = wrap_to;
    next_ptr = p;
    return r;
  endfunction

  function automatic map_res_t apply_req(input req_t it);
    map_res_t    r;
    logic [8:0]  mb;
    r = '0;
    if (it.op == OP_CACHE) begin
      if (it.bank == BANK_IGN_LO || it.bank == BANK_IGN_HI) r.status = STAT_IGNORED;
      else r = map_bank(it.bank, it.usage_type);
    end else begin
      mb = hirom_q ? {1'b0, it.rom_offset[23:16]} : it.rom_offset[23:15];
      miss_cnt[mb] = miss_cnt[mb] + 3'd1;
      if (miss_cnt[mb] > MISS_LIMIT) begin
        miss_cnt[mb] = 3'd0;
        r = map_bank(mb[7:0], TYPE_MISS);
      end else begin
        r.status = STAT_MISS;
      end
    end
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t        it;
    int unsigned roll;
    logic [8:0]  mb;
    logic [23:0] off;
    it.op = ($urandom_range(99) < 45) ? OP_MISS : OP_CACHE;
    roll = $urandom_range(99);
    if (roll < 60) it.bank = 8'($urandom_range(15));
    else if (roll < 68) it.bank = roll[0] ? BANK_IGN_HI : BANK_IGN_LO;
    else it.bank = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 3) it.usage_type = TYPE_RESIDENT;
    else if (roll < 20) it.usage_type = 8'h81;
    else if (roll < 40) it.usage_type = 8'h80;
    else if (roll < 70) it.usage_type = TYPE_MISS;
    else if (roll < 76) it.usage_type = TYPE_NONE;
    else it.usage_type = 8'($urandom);
    // a small set of banks so that misses reach the threshold
    mb = ($urandom_range(99) < 80) ? 9'($urandom_range(11)) : 9'($urandom);
    off = 24'($urandom);
    if ($urandom_range(9) == 0) it.rom_offset = off;
    else if (hirom_q) it.rom_offset = {mb[7:0], off[15:0]};
    else it.rom_offset = {mb, off[14:0]};
    return it;
  endfunction

  task automatic push_req(input logic o, input logic [7:0] b, input logic [7:0] t,
                          input logic [23:0] off);
    req_t it;
    it.op = o;
    it.bank = b;
    it.usage_type = t;
    it.rom_offset = off;
    req_backlog.push_back(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || chunk_decisions.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic h, input logic [7:0] bc, input logic [7:0] cc);
    logic [7:0] hdat;
    hdat = {7'($urandom), h};
    wait_idle();
    write_reg(CFG_HIROM, hdat);
    write_reg(CFG_BANK_COUNT, bc);
    write_reg(CFG_CHUNK_COUNT, cc);
    hirom_q = h;
    bank_count_q = bc;
    chunk_count_q = cc[6:0];
  endtask

  task automatic run_random(input logic h, input logic [7:0] bc, input logic [7:0] cc,
                            input int count);
    int k;
    set_config(h, bc, cc);
    for (k = 0; k < count; k++) req_backlog.push_back(rand_req());
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) chunk_decisions.push_back(apply_req(cur_req));
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_backlog.pop_front();
          in_valid <= 1'b1;
          op <= cur_req.op;
          bank <= cur_req.bank;
          usage_type <= cur_req.usage_type;
          rom_offset <= cur_req.rom_offset;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (chunk_decisions.size() == 0) begin
          $error("result item with no decision pending");
          mismatches++;
        end else begin
          want_res = chunk_decisions.pop_front();
          check_field("status", want_res.status, status);
          check_field("evicted_valid", want_res.evicted_valid, evicted_valid);
          check_field("evicted_bank", want_res.evicted_bank, evicted_bank);
          check_field("mapped_bank", want_res.mapped_bank, mapped_bank);
          check_field("chunk_index", want_res.chunk_index, chunk_index);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        !(req_backlog.size() != 0 || in_valid || chunk_decisions.size() != 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < NUM_BANKS; k++) begin
      bank_held[k] = 1'b0;
      bank_chunk[k] = 6'd0;
    end
    for (k = 0; k < NUM_CHUNKS; k++) begin
      chunk_type[k] = TYPE_NONE;
      chunk_bank[k] = 8'd0;
    end
    for (k = 0; k < NUM_MISS; k++) miss_cnt[k] = 3'd0;
    next_ptr = 0;
    hirom_q = 1'b0;
    bank_count_q = RST_BANK_COUNT;
    chunk_count_q = RST_CHUNK_COUNT;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: mask of zero folds every bank onto bank 0
    push_req(OP_CACHE, BANK_IGN_LO, 8'h80, 24'h000000);
    push_req(OP_CACHE, BANK_IGN_HI, 8'h80, 24'hFFFFFF);
    push_req(OP_CACHE, 8'h00, TYPE_RESIDENT, 24'h000000);
    push_req(OP_CACHE, 8'hFF, TYPE_MISS, 24'h000000);

    // four chunks: hit, type raise, stale entry, eviction, wrap to midpoint
    set_config(1'b0, 8'd128, 8'd4);
    push_req(OP_CACHE, 8'd1, TYPE_RESIDENT, 24'h0);
    push_req(OP_CACHE, 8'd2, 8'h80, 24'h0);
    push_req(OP_CACHE, 8'd1, TYPE_MISS, 24'h0);
    push_req(OP_CACHE, 8'd2, 8'h81, 24'h0);
    push_req(OP_CACHE, 8'd3, TYPE_NONE, 24'h0);
    push_req(OP_CACHE, 8'd4, 8'h81, 24'h0);
    push_req(OP_CACHE, 8'd5, TYPE_MISS, 24'h0);
    push_req(OP_CACHE, 8'd6, 8'h80, 24'h0);
    push_req(OP_CACHE, 8'd3, TYPE_MISS, 24'h0);
    for (k = 0; k < 5; k++) push_req(OP_MISS, 8'd0, 8'd0, {9'd7, 15'($urandom)});

    // hirom with a mask of all ones, misses on the top offset hit an ignored bank number
    set_config(1'b1, 8'd0, 8'd4);
    push_req(OP_CACHE, 8'hC0, 8'h81, 24'h0);
    for (k = 0; k < 5; k++) push_req(OP_MISS, 8'hFF, 8'hFF, 24'hFFFFFF);

    run_random(1'b0, 8'd128, 8'd64, 130);
    run_random(1'b1, 8'd64, 8'd16, 120);
    run_random(1'b0, 8'd255, 8'd2, 120);

    wait_idle();
    send_idle_pct = 48;
    recv_idle_pct = 21;
    run_random(1'b1, 8'd128, 8'd64, 120);
    run_random(1'b0, 8'd5, 8'd255, 120);
    run_random(1'b0, 8'd0, 8'd1, 110);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1'b1, 8'd1, 8'd0, 110);
    run_random(1'b0, 8'd128, 8'd3, 120);
    run_random(1'b1, 8'd32, 8'd64, 130);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
